// ===== src/tbot_pkg.sv =====
`default_nettype none
package tbot_pkg;

   // Pipeline depth: stage 1 and 2 front end, 3 to 7 axis and plane tests
   localparam int NUM_STAGES = 7;

   // One bit per pipeline stage, stage 1 in the lowest place
   typedef logic [NUM_STAGES:1] stage_en_type;

   // Register index port
   localparam int CSR_ADDR_W = 3;
   typedef logic [CSR_ADDR_W-1:0] csr_addr_type;

   localparam csr_addr_type CSR_CENTER_X  = 3'd0;
   localparam csr_addr_type CSR_CENTER_Y  = 3'd1;
   localparam csr_addr_type CSR_CENTER_Z  = 3'd2;
   localparam csr_addr_type CSR_HALF_SIZE = 3'd3;

   // Reset value of every register: 0.5 in Q16.16
   localparam int CSR_RESET = 32768;

endpackage
`default_nettype wire

// ===== src/tbot_front.sv =====
`default_nettype none
module tbot_front #(
   parameter int W = 32
) (
   input  wire logic                  clock,
   input  wire tbot_pkg::stage_en_type en,
   input  wire logic [9*W-1:0]        vert_in,
   input  wire logic [W-1:0]          center_x,
   input  wire logic [W-1:0]          center_y,
   input  wire logic [W-1:0]          center_z,
   input  wire logic [W-2:0]          half,
   output logic signed [W:0]          v_out [3][3],
   output logic signed [W+1:0]        e_out [3][3],
   output logic                       box_sep_out
);

   logic signed [W:0]   v1_in [3][3];
   logic signed [W:0]   v1_ff [3][3];
   logic signed [W:0]   v2_ff [3][3];
   logic signed [W+1:0] e_in  [3][3];
   logic signed [W+1:0] e_ff  [3][3];
   logic                box_in;
   logic                box_ff;
   logic [W-1:0]        cen [3];
   logic signed [W:0]   hx;

   assign cen[0] = center_x;
   assign cen[1] = center_y;
   assign cen[2] = center_z;

   // Move vertices so the cube center sits at the origin
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         for (int i = 0; i < 3; i++) begin
            v1_in[k][i] = $signed({vert_in[(3*k+i)*W+W-1], vert_in[(3*k+i)*W +: W]})
                        - $signed({cen[i][W-1], cen[i]});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         v1_ff <= v1_in;
      end
   end

   // Edges and box-face range tests
   assign hx = $signed({2'b00, half});

   always_comb begin
      box_in = 1'b0;
      for (int i = 0; i < 3; i++) begin
         e_in[0][i] = (W+2)'(v1_ff[1][i]) - (W+2)'(v1_ff[0][i]);
         e_in[1][i] = (W+2)'(v1_ff[2][i]) - (W+2)'(v1_ff[1][i]);
         e_in[2][i] = (W+2)'(v1_ff[0][i]) - (W+2)'(v1_ff[2][i]);
         if ((v1_ff[0][i] > hx) && (v1_ff[1][i] > hx) && (v1_ff[2][i] > hx)) begin
            box_in = 1'b1;
         end
         if ((v1_ff[0][i] < -hx) && (v1_ff[1][i] < -hx) && (v1_ff[2][i] < -hx)) begin
            box_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         v2_ff  <= v1_ff;
         e_ff   <= e_in;
         box_ff <= box_in;
      end
   end

   assign v_out       = v2_ff;
   assign e_out       = e_ff;
   assign box_sep_out = box_ff;

endmodule
`default_nettype wire

// ===== src/tbot_axis.sv =====
`default_nettype none
module tbot_axis #(
   parameter int W = 32
) (
   input  wire logic                  clock,
   input  wire tbot_pkg::stage_en_type en,
   input  wire logic [W-2:0]          half,
   input  wire logic signed [W:0]     v_in [3][3],
   input  wire logic signed [W+1:0]   e_in [3][3],
   input  wire logic                  box_sep_in,
   output logic                       sep_out
);

   localparam int PW = 2*W+3;
   localparam int DW = 2*W+4;
   localparam int RW = 2*W+2;

   logic signed [PW-1:0] pp_in [3][3][2][2];
   logic signed [PW-1:0] pp_ff [3][3][2][2];
   logic [W+2:0]         rs_in [3][3];
   logic [W+2:0]         rs_ff [3][3];
   logic signed [DW-1:0] p_in  [3][3][2];
   logic signed [DW-1:0] p_ff  [3][3][2];
   logic [RW-1:0]        r_in  [3][3];
   logic [RW-1:0]        r_ff  [3][3];
   logic [W+1:0]         ae    [3][3];
   logic                 sep5_in;
   logic                 box3_ff;
   logic                 box4_ff;
   logic                 sep5_ff;
   logic                 sep6_ff;
   logic                 sep7_ff;

   // Projection products of the two distinct vertices for the nine axes
   always_comb begin
      int a;
      int b;
      int u;
      int w;
      for (int j = 0; j < 3; j++) begin
         for (int i = 0; i < 3; i++) begin
            ae[j][i] = e_in[j][i][W+1] ? (W+2)'(-e_in[j][i]) : (W+2)'(e_in[j][i]);
         end
      end
      for (int j = 0; j < 3; j++) begin
         a = j;
         b = (j + 2) % 3;
         for (int m = 0; m < 3; m++) begin
            u = (m + 1) % 3;
            w = (m + 2) % 3;
            pp_in[j][m][0][0] = e_in[j][u] * v_in[a][w];
            pp_in[j][m][0][1] = e_in[j][w] * v_in[a][u];
            pp_in[j][m][1][0] = e_in[j][u] * v_in[b][w];
            pp_in[j][m][1][1] = e_in[j][w] * v_in[b][u];
            rs_in[j][m] = {1'b0, ae[j][u]} + {1'b0, ae[j][w]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         pp_ff   <= pp_in;
         rs_ff   <= rs_in;
         box3_ff <= box_sep_in;
      end
   end

   // Projections and radii
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         for (int m = 0; m < 3; m++) begin
            for (int t = 0; t < 2; t++) begin
               p_in[j][m][t] = DW'(pp_ff[j][m][t][0]) - DW'(pp_ff[j][m][t][1]);
            end
            r_in[j][m] = rs_ff[j][m] * half;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         p_ff    <= p_in;
         r_ff    <= r_in;
         box4_ff <= box3_ff;
      end
   end

   // Separate when the box-face test did, or both projections fall on one side of the radius
   always_comb begin
      logic signed [DW:0] rr;
      sep5_in = box4_ff;
      for (int j = 0; j < 3; j++) begin
         for (int m = 0; m < 3; m++) begin
            rr = $signed({3'b000, r_ff[j][m]});
            if ((p_ff[j][m][0] > rr) && (p_ff[j][m][1] > rr)) begin
               sep5_in = 1'b1;
            end
            if ((p_ff[j][m][0] < -rr) && (p_ff[j][m][1] < -rr)) begin
               sep5_in = 1'b1;
            end
         end
      end
   end

   // Hold the verdict in step with the plane test
   always_ff @(posedge clock) begin
      if (en[5]) begin
         sep5_ff <= sep5_in;
      end
      if (en[6]) begin
         sep6_ff <= sep5_ff;
      end
      if (en[7]) begin
         sep7_ff <= sep6_ff;
      end
   end

   assign sep_out = sep7_ff;

endmodule
`default_nettype wire

// ===== src/tbot_plane.sv =====
`default_nettype none
module tbot_plane #(
   parameter int W = 32
) (
   input  wire logic                  clock,
   input  wire tbot_pkg::stage_en_type en,
   input  wire logic [W-2:0]          half,
   input  wire logic signed [W:0]     v_in [3][3],
   input  wire logic signed [W+1:0]   e_in [3][3],
   output logic                       sep_out
);

   localparam int PW = 2*W+3;   // normal partial product
   localparam int NW = 2*W+4;   // normal component
   localparam int L  = W+2;     // split point of wide operands
   localparam int SW = 2*W+6;   // sum of normal magnitudes
   localparam int DW = 3*W+7;   // n . v0
   localparam int HW = 3*W+5;   // h * S
   localparam int CW = 3*W+9;   // compare width

   logic signed [W+1:0]   f     [3];
   logic signed [PW-1:0]  mu_in [3][2];
   logic signed [PW-1:0]  mu_ff [3][2];
   logic signed [W:0]     v03_ff [3];
   logic signed [W:0]     v04_ff [3];
   logic signed [NW-1:0]  n_in  [3];
   logic signed [NW-1:0]  n_ff  [3];
   logic [NW-1:0]         an    [3];
   logic [SW-1:0]         s_in;
   logic [SW-1:0]         s_ff;
   logic signed [2*W+3:0] plo_in [3];
   logic signed [2*W+3:0] plo_ff [3];
   logic signed [2*W+2:0] phi_in [3];
   logic signed [2*W+2:0] phi_ff [3];
   logic signed [DW-1:0]  dsum_in;
   logic signed [DW-1:0]  dsum_ff;
   logic [2*W:0]          hl_in;
   logic [2*W:0]          hl_ff;
   logic [2*W+2:0]        hh_in;
   logic [2*W+2:0]        hh_ff;
   logic                  sep_in;
   logic                  sep_ff;

   // Normal partial products: e0 x (v2 - v0)
   always_comb begin
      int u;
      int w;
      for (int i = 0; i < 3; i++) begin
         f[i] = (W+2)'(v_in[2][i]) - (W+2)'(v_in[0][i]);
      end
      for (int i = 0; i < 3; i++) begin
         u = (i + 1) % 3;
         w = (i + 2) % 3;
         mu_in[i][0] = e_in[0][u] * f[w];
         mu_in[i][1] = e_in[0][w] * f[u];
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         mu_ff  <= mu_in;
         v03_ff <= v_in[0];
      end
   end

   // Normal components
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n_in[i] = NW'(mu_ff[i][0]) - NW'(mu_ff[i][1]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         n_ff   <= n_in;
         v04_ff <= v03_ff;
      end
   end

   // Magnitude sum and split products n * v0
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         an[i]     = n_ff[i][NW-1] ? NW'(-n_ff[i]) : NW'(n_ff[i]);
         plo_in[i] = $signed({1'b0, n_ff[i][L-1:0]}) * v04_ff[i];
         phi_in[i] = $signed(n_ff[i][NW-1:L]) * v04_ff[i];
      end
      s_in = SW'(an[0]) + SW'(an[1]) + SW'(an[2]);
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         plo_ff <= plo_in;
         phi_ff <= phi_in;
         s_ff   <= s_in;
      end
   end

   // Merge partial products into n . v0, split h * S
   always_comb begin
      logic signed [DW-1:0] t_hi;
      logic signed [DW-1:0] t_lo;
      dsum_in = '0;
      for (int i = 0; i < 3; i++) begin
         t_hi    = phi_ff[i];
         t_hi    = t_hi <<< L;
         t_lo    = plo_ff[i];
         dsum_in = dsum_in + t_hi + t_lo;
      end
      hl_in = s_ff[L-1:0] * half;
      hh_in = s_ff[SW-1:L] * half;
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         dsum_ff <= dsum_in;
         hl_ff   <= hl_in;
         hh_ff   <= hh_in;
      end
   end

   // Plane separates when n . v0 lies outside [-h*S, h*S]
   always_comb begin
      logic [HW-1:0]        hs;
      logic signed [CW-1:0] hsx;
      logic signed [CW-1:0] ds;
      hs     = (HW'(hh_ff) << L) + HW'(hl_ff);
      hsx    = $signed({4'b0000, hs});
      ds     = dsum_ff;
      sep_in = (ds > hsx) || (ds < -hsx);
   end

   always_ff @(posedge clock) begin
      if (en[7]) begin
         sep_ff <= sep_in;
      end
   end

   assign sep_out = sep_ff;

endmodule
`default_nettype wire

// ===== src/triangle_box_overlap_test_unit.sv =====
`default_nettype none
// Seven register stages; an accepted req transaction moves through the valid bits
// of stages 1 to 7 in order, and rsp_tvalid is the valid bit of stage 7.
// Throughput: one triangle per cycle while the output is not stalled; each
// of the seven stages has its own valid bit and advances when the stage
// after it frees up, so the output register alone sets the stall point.
// Reset: synchronous; clears all valid bits and sets center and half size to 0.5.
module triangle_box_overlap_test_unit #(
   parameter int COORD_WIDTH = 32
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // vertex0_x, vertex0_y, vertex0_z, vertex1_x .. vertex2_z, low bits first
   input  wire logic [((9*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // overlap in bit 0
   output logic [7:0]                            rsp_tdata,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   input  wire logic                             csr_we,
   input  wire tbot_pkg::csr_addr_type           csr_addr,
   input  wire logic [COORD_WIDTH-1:0]           csr_wdata
);

   localparam int W = COORD_WIDTH;

   logic [W-1:0]           center_x_ff;
   logic [W-1:0]           center_y_ff;
   logic [W-1:0]           center_z_ff;
   logic [W-2:0]           half_ff;
   tbot_pkg::stage_en_type en;
   tbot_pkg::stage_en_type valid_ff;
   logic signed [W:0]      v2     [3][3];
   logic signed [W+1:0]    e2     [3][3];
   logic                   box_sep;
   logic                   axis_sep;
   logic                   plane_sep;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= W'(tbot_pkg::CSR_RESET);
         center_y_ff <= W'(tbot_pkg::CSR_RESET);
         center_z_ff <= W'(tbot_pkg::CSR_RESET);
         half_ff     <= (W-1)'(tbot_pkg::CSR_RESET);
      end else if (csr_we) begin
         unique case (csr_addr)
            tbot_pkg::CSR_CENTER_X:  center_x_ff <= csr_wdata;
            tbot_pkg::CSR_CENTER_Y:  center_y_ff <= csr_wdata;
            tbot_pkg::CSR_CENTER_Z:  center_z_ff <= csr_wdata;
            tbot_pkg::CSR_HALF_SIZE: half_ff     <= csr_wdata[W-2:0];
            default: ;
         endcase
      end
   end

   // Stage load enables: a stage loads when empty or when its successor moves
   always_comb begin
      en[tbot_pkg::NUM_STAGES] = !valid_ff[tbot_pkg::NUM_STAGES] || rsp_tready;
      for (int k = tbot_pkg::NUM_STAGES - 1; k >= 1; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[1]) begin
            valid_ff[1] <= req_tvalid;
         end
         for (int k = 2; k <= tbot_pkg::NUM_STAGES; k++) begin
            if (en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   assign req_tready = en[1];

   tbot_front #(.W(W)) u_front (
      .clock       (clock),
      .en          (en),
      .vert_in     (req_tdata[9*W-1:0]),
      .center_x    (center_x_ff),
      .center_y    (center_y_ff),
      .center_z    (center_z_ff),
      .half        (half_ff),
      .v_out       (v2),
      .e_out       (e2),
      .box_sep_out (box_sep)
   );

   tbot_axis #(.W(W)) u_axis (
      .clock      (clock),
      .en         (en),
      .half       (half_ff),
      .v_in       (v2),
      .e_in       (e2),
      .box_sep_in (box_sep),
      .sep_out    (axis_sep)
   );

   tbot_plane #(.W(W)) u_plane (
      .clock   (clock),
      .en      (en),
      .half    (half_ff),
      .v_in    (v2),
      .e_in    (e2),
      .sep_out (plane_sep)
   );

   assign rsp_tvalid = valid_ff[tbot_pkg::NUM_STAGES];
   assign rsp_tdata  = {7'b0000000, !(axis_sep || plane_sep)};

`ifndef NO_ASSERTIONS
   // Pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (valid_ff == '0))
      else $error("pipeline not empty after reset");

   // A full pipeline with a stalled output takes no transaction
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      ((&valid_ff) && !rsp_tready) |-> !req_tready)
      else $error("accepted into a full stalled pipeline");

   // An accepted transaction reaches stage 1
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> valid_ff[1])
      else $error("accepted transaction lost at stage 1");

   // Stage 4 becomes valid when it loads from a valid stage 3
   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      (en[4] && valid_ff[3]) |=> valid_ff[4])
      else $error("transaction dropped between stages");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/triangle_box_overlap_test_unit_tb.sv =====
`default_nettype none
module triangle_box_overlap_test_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [255:0] wide_type;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int LONG_HOLD = 80;
   localparam int PIPE_DRAIN = 20;

   logic                   clock;
   logic                   reset;
   logic [287:0]           req_tdata;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [7:0]             rsp_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic                   csr_we;
   tbot_pkg::csr_addr_type csr_addr;
   logic [31:0]            csr_wdata;

   triangle_box_overlap_test_unit i_dut (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   // Cube settings as the block should hold them
   logic [31:0] cube_center [3];
   logic [30:0] cube_half;

   // Vertices of the triangle being predicted: v0 xyz, v1 xyz, v2 xyz
   logic [31:0] tri_vtx [9];

   bit          overlap_queue [$];
   int          error_count = 0;
   int          cycle_count = 0;
   bit          hold_request = 0;
   bit          no_idle = 0;

   initial begin
      clock = 0;
      forever begin
         #5 clock = ~clock;
         if (clock) begin
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
               $display("%0t: timeout, %0d results outstanding", $realtime,
                        overlap_queue.size());
               $display("** triangle_box_overlap_test_unit: FAILED **");
               $finish;
            end
         end
      end
   end

   function automatic wide_type wabs(wide_type a);
      return (a < 0) ? -a : a;
   endfunction

   function automatic bit range_separates(wide_type pa, wide_type pb, wide_type r);
      wide_type hi, lo;
      hi = (pb > pa) ? pb : pa;
      lo = (pb > pa) ? pa : pb;
      return (-r > hi) || (lo > r);
   endfunction

   // Three axes: each box axis crossed with edge e, projecting vertices a and b
   function automatic bit edge_axes_separate(wide_type a0, wide_type a1, wide_type a2,
                                             wide_type b0, wide_type b1, wide_type b2,
                                             wide_type e0, wide_type e1, wide_type e2,
                                             wide_type h);
      wide_type fx, fy, fz;
      fx = wabs(e0);
      fy = wabs(e1);
      fz = wabs(e2);
      if (range_separates(e1*a2 - e2*a1, e1*b2 - e2*b1, (fz + fy)*h)) return 1;
      if (range_separates(e2*a0 - e0*a2, e2*b0 - e0*b2, (fz + fx)*h)) return 1;
      return range_separates(e0*a1 - e1*a0, e0*b1 - e1*b0, (fy + fx)*h);
   endfunction

   // Separating-axis decision for the triangle in tri_vtx
   function automatic bit predict_overlap();
      wide_type v [3][3];
      wide_type e [3][3];
      wide_type f [3];
      wide_type c, h, n0, n1, n2, d, hs;
      h = {225'd0, cube_half};
      for (int i = 0; i < 3; i++) begin
         c = $signed(cube_center[i]);
         for (int k = 0; k < 3; k++) v[k][i] = wide_type'($signed(tri_vtx[k*3+i])) - c;
      end
      for (int i = 0; i < 3; i++) begin
         e[0][i] = v[1][i] - v[0][i];
         e[1][i] = v[2][i] - v[1][i];
         e[2][i] = v[0][i] - v[2][i];
         f[i] = v[2][i] - v[0][i];
      end
      if (edge_axes_separate(v[0][0], v[0][1], v[0][2], v[2][0], v[2][1], v[2][2],
                             e[0][0], e[0][1], e[0][2], h)) return 0;
      if (edge_axes_separate(v[1][0], v[1][1], v[1][2], v[0][0], v[0][1], v[0][2],
                             e[1][0], e[1][1], e[1][2], h)) return 0;
      if (edge_axes_separate(v[2][0], v[2][1], v[2][2], v[1][0], v[1][1], v[1][2],
                             e[2][0], e[2][1], e[2][2], h)) return 0;
      // Box face ranges
      for (int i = 0; i < 3; i++) begin
         if (v[0][i] > h && v[1][i] > h && v[2][i] > h) return 0;
         if (-h > v[0][i] && -h > v[1][i] && -h > v[2][i]) return 0;
      end
      // Triangle plane, exact zero tolerance
      n0 = e[0][1]*f[2] - e[0][2]*f[1];
      n1 = e[0][2]*f[0] - e[0][0]*f[2];
      n2 = e[0][0]*f[1] - e[0][1]*f[0];
      d  = -(n0*v[0][0] + n1*v[0][1] + n2*v[0][2]);
      hs = (wabs(n0) + wabs(n1) + wabs(n2)) * h;
      if (d - hs > 0) return 0;
      if (d + hs < 0) return 0;
      return 1;
   endfunction

   function automatic int idle_cycles();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Write one register, then wait with the port idle
   task automatic write_csr(tbot_pkg::csr_addr_type addr, logic [31:0] data);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= data;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (addr)
         tbot_pkg::CSR_CENTER_X:  cube_center[0] = data;
         tbot_pkg::CSR_CENTER_Y:  cube_center[1] = data;
         tbot_pkg::CSR_CENTER_Z:  cube_center[2] = data;
         tbot_pkg::CSR_HALF_SIZE: cube_half = data[30:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Offer one triangle; queue its expected overlap once accepted
   task automatic send_triangle(int fixed_overlap);
      int n;
      logic [287:0] pkt;
      n = idle_cycles();
      pkt = '0;
      for (int j = 0; j < 9; j++) pkt[32*j +: 32] = tri_vtx[j];
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_tdata  <= pkt;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      overlap_queue.push_back(fixed_overlap >= 0 ? fixed_overlap[0] : predict_overlap());
   endtask

   task automatic wait_drained();
      while (overlap_queue.size() != 0) @(posedge clock);
   endtask

   // Coordinate near the cube on one axis, or anywhere
   function automatic logic [31:0] pick_coord(int axis, bit near_cube);
      longint lim;
      if (!near_cube) return $urandom();
      lim = longint'(cube_half) * 3 + 4;
      if (lim > 64'h4000_0000) lim = 64'h4000_0000;
      if ($urandom_range(0, 3) == 0) lim = 8;
      return cube_center[axis] + 32'(longint'($urandom_range(0, 32'(2*lim))) - lim);
   endfunction

   // Directed triangles under the reset cube [0,1]^3; -1 means predicted
   typedef struct {
      logic [31:0] vtx [9];
      int          overlap;
   } directed_row_type;

   directed_row_type directed [12];

   initial begin
      // Degenerate point at the cube corner touches it
      directed[0] = '{'{0,0,0, 0,0,0, 0,0,0}, 1};
      directed[1] = '{'{32'h10000,32'h10000,32'h10000, 32'h10000,32'h10000,32'h10000,
                        32'h10000,32'h10000,32'h10000}, 1};
      directed[2] = '{'{32'h10001,0,0, 32'h10001,0,0, 32'h10001,0,0}, 0};
      directed[3] = '{'{32'h7fffffff,32'h7fffffff,32'h7fffffff,
                        32'h7fffffff,32'h7fffffff,32'h7fffffff,
                        32'h7fffffff,32'h7fffffff,32'h7fffffff}, 0};
      directed[4] = '{'{32'h80000000,32'h80000000,32'h80000000,
                        32'h80000000,32'h80000000,32'h80000000,
                        32'h80000000,32'h80000000,32'h80000000}, 0};
      directed[5] = '{'{32'h80000000,32'h80000000,32'h80000000,
                        32'h7fffffff,32'h7fffffff,32'h7fffffff,
                        32'h7fffffff,32'h80000000,32'h80000000}, -1};
      // Big triangle through the cube
      directed[6] = '{'{32'hfff00000,32'h8000,32'h8000, 32'h100000,32'h8000,32'hfff00000,
                        32'h100000,32'h8000,32'h100000}, -1};
      // Plane touches the far cube corner, then one that cuts through the cube
      directed[7] = '{'{32'h30000,0,0, 0,32'h30000,0, 0,0,32'h30000}, -1};
      directed[8] = '{'{32'h18000,0,0, 0,32'h18000,0, 0,0,32'h18000}, -1};
      // Collinear, degenerate normal
      directed[9] = '{'{32'hfffe0000,32'hfffe0000,32'hfffe0000, 32'h8000,32'h8000,32'h8000,
                        32'h30000,32'h30000,32'h30000}, -1};
      // Edge only touches a cube face
      directed[10] = '{'{32'h10000,32'hfff00000,32'h8000, 32'h10000,32'h100000,32'h8000,
                         32'h20000,32'h8000,32'h8000}, -1};
      directed[11] = '{'{32'hffffffff,32'h8000,32'h8000, 32'hffffffff,32'h10000,32'h8000,
                         32'hfffe0000,32'h8000,32'h8000}, 0};
   end

   // Receiver: random back pressure, plus one long hold on request
   initial begin
      int n;
      rsp_tready <= 1'b0;
      @(negedge reset);
      forever begin
         n = idle_cycles();
         if (hold_request) begin
            n = LONG_HOLD;
            hold_request = 0;
         end
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   // Check each result transaction against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (overlap_queue.size() == 0) begin
            $display("%0t: unexpected result, actual overlap=%0b", $realtime, rsp_tdata[0]);
            error_count++;
         end else begin
            if (rsp_tdata[0] !== overlap_queue[0]) begin
               $display("%0t: overlap mismatch, expected %0b actual %0b", $realtime,
                        overlap_queue[0], rsp_tdata[0]);
               error_count++;
            end
            void'(overlap_queue.pop_front());
         end
      end
   end

   initial begin
      int sent;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_we     <= 1'b0;
      csr_addr   <= tbot_pkg::CSR_CENTER_X;
      csr_wdata  <= '0;
      for (int i = 0; i < 3; i++) cube_center[i] = tbot_pkg::CSR_RESET;
      cube_half = 31'(tbot_pkg::CSR_RESET);
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows under the reset cube
      foreach (directed[r]) begin
         tri_vtx = directed[r].vtx;
         send_triangle(directed[r].overlap);
      end

      sent = 0;
      for (int phase = 0; phase < 11; phase++) begin
         // Reconfigure only with the pipeline empty
         req_tvalid <= 1'b0;
         wait_drained();
         repeat (PIPE_DRAIN) @(posedge clock);
         case (phase)
            0: ;
            1: begin
               write_csr(tbot_pkg::CSR_CENTER_X, 0);
               write_csr(tbot_pkg::CSR_CENTER_Y, 0);
               write_csr(tbot_pkg::CSR_CENTER_Z, 0);
               write_csr(tbot_pkg::CSR_HALF_SIZE, 0);
            end
            2: begin
               write_csr(tbot_pkg::CSR_CENTER_X, 32'h7fffffff);
               write_csr(tbot_pkg::CSR_CENTER_Y, 32'h80000000);
               write_csr(tbot_pkg::CSR_CENTER_Z, 32'h7fffffff);
               write_csr(tbot_pkg::CSR_HALF_SIZE, 32'h7fffffff);
            end
            3: begin
               write_csr(tbot_pkg::CSR_CENTER_X, 32'h80000000);
               write_csr(tbot_pkg::CSR_CENTER_Y, 32'h7fffffff);
               write_csr(tbot_pkg::CSR_CENTER_Z, 32'h80000000);
               write_csr(tbot_pkg::CSR_HALF_SIZE, 1);
            end
            default: begin
               write_csr(tbot_pkg::CSR_CENTER_X,
                         $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 32'h80000));
               write_csr(tbot_pkg::CSR_CENTER_Y,
                         $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 32'h80000));
               write_csr(tbot_pkg::CSR_CENTER_Z,
                         $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 32'h80000));
               // Bit 31 lies above the half size and must be dropped
               write_csr(tbot_pkg::CSR_HALF_SIZE,
                         {1'($urandom()), 31'($urandom_range(1, 32'h40000))});
               // Writes to unused indexes change nothing
               write_csr(tbot_pkg::csr_addr_type'($urandom_range(4, 7)), $urandom());
            end
         endcase
         no_idle = (phase % 4 == 1);
         for (int t = 0; t < 150; t++) begin
            bit near_cube;
            near_cube = ($urandom_range(0, 9) < 7);
            for (int j = 0; j < 9; j++) tri_vtx[j] = pick_coord(j % 3, near_cube);
            // Some degenerate triangles with shared vertices
            if ($urandom_range(0, 9) == 0)
               for (int j = 0; j < 3; j++) tri_vtx[3+j] = tri_vtx[j];
            sent++;
            if (sent == 300) hold_request = 1;
            if (sent == 900) begin
               req_tvalid <= 1'b0;
               wait_drained();
            end
            send_triangle(-1);
         end
      end
      req_tvalid <= 1'b0;

      wait_drained();
      repeat (PIPE_DRAIN) @(posedge clock);
      if (error_count == 0 && overlap_queue.size() == 0) begin
         $display("** triangle_box_overlap_test_unit: PASSED **");
      end else begin
         $display("** triangle_box_overlap_test_unit: FAILED **");
      end
      $finish;
   end

endmodule
`default_nettype wire
